// ----- hdl/ising_pkg.sv -----
// ----------------------------------------------------------------------------
// ising_pkg
// Shared types and constants for the Ising Metropolis spin update block.
// ----------------------------------------------------------------------------
package ising_pkg;

   // field widths
   localparam int ROW_W      = 7;
   localparam int RND_W      = 32;
   localparam int THR_W      = 33;
   localparam int ABS_W      = 48;
   localparam int OUT_SUM_W  = 16;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 5;

   // threshold register indexes (paddr[4:3])
   typedef enum logic [1:0] {
      REG_THR_M4 = 2'd0,
      REG_THR_M2 = 2'd1,
      REG_THR_P2 = 2'd2,
      REG_THR_P4 = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [THR_W-1:0] m4;
      logic [THR_W-1:0] m2;
      logic [THR_W-1:0] p2;
      logic [THR_W-1:0] p4;
   } thr_set_type;

   // lattice row read select
   typedef enum logic [1:0] {
      RD_UP  = 2'd0,
      RD_DN  = 2'd1,
      RD_MID = 2'd2
   } rd_sel_type;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_SWEEP  = 7'b0000010,
      S_RD_UP  = 7'b0000100,
      S_RD_DN  = 7'b0001000,
      S_RD_MID = 7'b0010000,
      S_EVAL   = 7'b0100000,
      S_ACC    = 7'b1000000
   } state_type;

   typedef struct packed {
      logic       load;        // latch request word
      logic       rd_en;       // issue lattice row read
      rd_sel_type rd_sel;
      logic       cap_up;      // keep up-neighbor bit
      logic       cap_dn;      // keep down-neighbor bit
      logic       eval;        // decide flip, write row back
      logic       accum;       // abs total add, send result
      logic       sweep;       // zero one lattice row
      logic       clear_done;  // reset sums after sweep
      logic       report;      // send result for a clear word
   } dp_cmd_type;

   typedef struct packed {
      logic sweep_last;
   } dp_status_type;

endpackage

// ----- hdl/ising_csr.sv -----
// ----------------------------------------------------------------------------
// ising_csr
// APB-style register file holding the four acceptance thresholds.
// ----------------------------------------------------------------------------
module ising_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ising_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [ising_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [ising_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                              pready,
   output ising_pkg::thr_set_type            thr
);
   import ising_pkg::*;

   localparam logic [THR_W-1:0] THR_RESET = {1'b1, {(THR_W-1){1'b0}}};

   thr_set_type   thr_ff, thr_in;
   reg_index_type idx;
   logic          wr_en;
   logic [THR_W-1:0] rd_val;

   assign idx    = reg_index_type'(paddr[4:3]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      thr_in = thr_ff;
      if (wr_en) begin
         unique case (idx)
            REG_THR_M4: thr_in.m4 = pwdata[THR_W-1:0];
            REG_THR_M2: thr_in.m2 = pwdata[THR_W-1:0];
            REG_THR_P2: thr_in.p2 = pwdata[THR_W-1:0];
            REG_THR_P4: thr_in.p4 = pwdata[THR_W-1:0];
            default:    thr_in = thr_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_THR_M4: rd_val = thr_ff.m4;
         REG_THR_M2: rd_val = thr_ff.m2;
         REG_THR_P2: rd_val = thr_ff.p2;
         REG_THR_P4: rd_val = thr_ff.p4;
         default:    rd_val = '0;
      endcase
   end

   assign prdata = CSR_DATA_W'(rd_val);
   assign thr    = thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '{THR_RESET, THR_RESET, THR_RESET, THR_RESET};
      end else begin
         thr_ff <= thr_in;
      end
   end

endmodule

// ----- hdl/ising_ctrl.sv -----
// ----------------------------------------------------------------------------
// ising_ctrl
// Sequencer: lattice clearing sweep and the five-step Metropolis update.
// ----------------------------------------------------------------------------
module ising_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      req_mode,
   input  ising_pkg::dp_status_type  status,
   output ising_pkg::dp_cmd_type     cmd,
   output logic                      busy
);
   import ising_pkg::*;

   state_type state_ff, state_in;
   logic      clr_item_ff, clr_item_in;

   always_comb begin
      state_in    = state_ff;
      clr_item_in = clr_item_ff;
      cmd         = '0;
      cmd.rd_sel  = RD_MID;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (req_mode) begin
                  state_in    = S_SWEEP;
                  clr_item_in = 1'b1;
               end else begin
                  state_in = S_RD_UP;
               end
            end
         end
         S_SWEEP: begin
            cmd.sweep = 1'b1;
            if (status.sweep_last) begin
               cmd.clear_done = 1'b1;
               cmd.report     = clr_item_ff;
               clr_item_in    = 1'b0;
               state_in       = S_IDLE;
            end
         end
         S_RD_UP: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_UP;
            state_in   = S_RD_DN;
         end
         S_RD_DN: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_DN;
            cmd.cap_up = 1'b1;
            state_in   = S_RD_MID;
         end
         S_RD_MID: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_MID;
            cmd.cap_dn = 1'b1;
            state_in   = S_EVAL;
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.accum = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in    = S_SWEEP;
            clr_item_in = 1'b0;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_SWEEP;   // clear the lattice after reset
         clr_item_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_item_ff <= clr_item_in;
      end
   end

endmodule

// ----- hdl/ising_dp.sv -----
// ----------------------------------------------------------------------------
// ising_dp
// Lattice memory (one row per word), neighbor gather, flip decision and sums.
// ----------------------------------------------------------------------------
module ising_dp #(
   parameter int SIDE = 128
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ising_pkg::dp_cmd_type               cmd,
   output ising_pkg::dp_status_type            status,
   input  logic [ising_pkg::ROW_W-1:0]         req_row,
   input  logic [ising_pkg::ROW_W-1:0]         req_col,
   input  logic [ising_pkg::RND_W-1:0]         req_random_fraction,
   input  ising_pkg::thr_set_type              thr,
   output logic                                rsp_strobe,
   output logic                                rsp_flipped,
   output logic                                rsp_site_spin,
   output logic signed [ising_pkg::OUT_SUM_W-1:0] rsp_spin_sum,
   output logic [ising_pkg::ABS_W-1:0]         rsp_abs_spin_sum_total
);
   import ising_pkg::*;

   localparam int IDX_W = $clog2(SIDE);
   localparam int SUM_W = $clog2(SIDE * SIDE) + 2;
   localparam int EXT_W = (SUM_W > OUT_SUM_W) ? SUM_W : OUT_SUM_W;
   localparam logic [IDX_W-1:0]        LAST_IDX  = IDX_W'(SIDE - 1);
   localparam logic signed [SUM_W-1:0] SUM_RESET = SUM_W'(-(SIDE * SIDE));
   localparam logic signed [EXT_W-1:0] EXT_RESET = EXT_W'(-(SIDE * SIDE));

   // row/col reduced modulo SIDE: small constant table over the 7-bit field
   function automatic logic [IDX_W-1:0] wrap_index(input logic [ROW_W-1:0] v);
      logic [IDX_W-1:0] res;
      res = '0;
      for (int i = 0; i < 2**ROW_W; i++) begin
         if (v == ROW_W'(i)) res = IDX_W'(i % SIDE);
      end
      return res;
   endfunction

   logic [SIDE-1:0] lattice_mem [SIDE];

   logic [IDX_W-1:0] r_ff, c_ff, sweep_ff, sweep_in;
   logic [RND_W-1:0] rnd_ff;
   logic             up_bit_ff, dn_bit_ff;
   logic [SIDE-1:0]  rd_row_ff;
   logic signed [SUM_W-1:0] total_ff, total_in, total_next;
   logic [ABS_W-1:0] abs_ff, abs_in, abs_acc;
   logic [ABS_W:0]   abs_sum;
   logic [SUM_W-1:0] mag;
   logic             flipped_ff, spin_ff;
   logic             strobe_ff, strobe_in;
   logic             o_flip_ff, o_flip_in, o_spin_ff, o_spin_in;
   logic signed [OUT_SUM_W-1:0] o_sum_ff, o_sum_in;
   logic [ABS_W-1:0] o_abs_ff, o_abs_in;
   logic signed [EXT_W-1:0] total_ext;

   logic [IDX_W-1:0] up_idx, dn_idx, lf_idx, rt_idx, rd_addr, wr_addr;
   logic             self_bit, lf_bit, rt_bit, accept;
   logic [2:0]       aligned;
   logic [SIDE-1:0]  new_row, wr_row;
   logic             mem_we;
   logic [THR_W-1:0] rnd_ext;

   // periodic neighbors
   assign up_idx = (r_ff == '0)       ? LAST_IDX : r_ff - IDX_W'(1);
   assign dn_idx = (r_ff == LAST_IDX) ? '0       : r_ff + IDX_W'(1);
   assign lf_idx = (c_ff == '0)       ? LAST_IDX : c_ff - IDX_W'(1);
   assign rt_idx = (c_ff == LAST_IDX) ? '0       : c_ff + IDX_W'(1);

   always_comb begin
      unique case (cmd.rd_sel)
         RD_UP:   rd_addr = up_idx;
         RD_DN:   rd_addr = dn_idx;
         RD_MID:  rd_addr = r_ff;
         default: rd_addr = r_ff;
      endcase
   end

   // row in rd_row_ff is the site's own row during eval
   assign self_bit = rd_row_ff[c_ff];
   assign lf_bit   = rd_row_ff[lf_idx];
   assign rt_bit   = rd_row_ff[rt_idx];

   // neighbors equal to the site spin; product s*sum = 2*aligned - 4
   assign aligned = 3'(up_bit_ff == self_bit) + 3'(dn_bit_ff == self_bit)
                  + 3'(lf_bit == self_bit) + 3'(rt_bit == self_bit);

   assign rnd_ext = {1'b0, rnd_ff};

   always_comb begin
      unique case (aligned)
         3'd0:    accept = (rnd_ext <= thr.m4);
         3'd1:    accept = (rnd_ext <= thr.m2);
         3'd2:    accept = 1'b1;            // zero product
         3'd3:    accept = (rnd_ext <= thr.p2);
         default: accept = (rnd_ext <= thr.p4);
      endcase
   end

   always_comb begin
      new_row       = rd_row_ff;
      new_row[c_ff] = self_bit ^ accept;
   end

   always_comb begin
      total_next = total_ff;
      if (accept) begin
         total_next = self_bit ? total_ff - SUM_W'(2) : total_ff + SUM_W'(2);
      end
   end

   // saturating add of |total|
   assign mag     = total_ff[SUM_W-1] ? $unsigned(-total_ff) : $unsigned(total_ff);
   assign abs_sum = {1'b0, abs_ff} + (ABS_W + 1)'(mag);
   assign abs_acc = abs_sum[ABS_W] ? '1 : abs_sum[ABS_W-1:0];

   assign total_ext = EXT_W'(total_ff);

   // memory write port: sweep or write-back
   assign mem_we  = cmd.sweep || cmd.eval;
   assign wr_addr = cmd.sweep ? sweep_ff : r_ff;
   assign wr_row  = cmd.sweep ? '0 : new_row;

   assign status.sweep_last = (sweep_ff == LAST_IDX);

   always_comb begin
      sweep_in = sweep_ff;
      if (cmd.sweep) begin
         sweep_in = status.sweep_last ? '0 : sweep_ff + IDX_W'(1);
      end
   end

   always_comb begin
      total_in = total_ff;
      abs_in   = abs_ff;
      priority if (cmd.clear_done) begin
         total_in = SUM_RESET;
         abs_in   = '0;
      end else if (cmd.eval) begin
         total_in = total_next;
      end else if (cmd.accum) begin
         abs_in = abs_acc;
      end
   end

   always_comb begin
      strobe_in = cmd.accum || (cmd.clear_done && cmd.report);
      o_flip_in = o_flip_ff;
      o_spin_in = o_spin_ff;
      o_sum_in  = o_sum_ff;
      o_abs_in  = o_abs_ff;
      priority if (cmd.accum) begin
         o_flip_in = flipped_ff;
         o_spin_in = spin_ff;
         o_sum_in  = total_ext[OUT_SUM_W-1:0];
         o_abs_in  = abs_acc;
      end else if (cmd.clear_done && cmd.report) begin
         o_flip_in = 1'b0;
         o_spin_in = 1'b0;
         o_sum_in  = EXT_RESET[OUT_SUM_W-1:0];
         o_abs_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         lattice_mem[wr_addr] <= wr_row;
      end
      if (cmd.rd_en) begin
         rd_row_ff <= lattice_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         r_ff   <= wrap_index(req_row);
         c_ff   <= wrap_index(req_col);
         rnd_ff <= req_random_fraction;
      end
      if (cmd.cap_up) up_bit_ff <= rd_row_ff[c_ff];
      if (cmd.cap_dn) dn_bit_ff <= rd_row_ff[c_ff];
      if (cmd.eval) begin
         flipped_ff <= accept;
         spin_ff    <= self_bit ^ accept;
      end
      o_flip_ff <= o_flip_in;
      o_spin_ff <= o_spin_in;
      o_sum_ff  <= o_sum_in;
      o_abs_ff  <= o_abs_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff  <= '0;
         total_ff  <= SUM_RESET;
         abs_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         sweep_ff  <= sweep_in;
         total_ff  <= total_in;
         abs_ff    <= abs_in;
         strobe_ff <= strobe_in;
      end
   end

   assign rsp_strobe             = strobe_ff;
   assign rsp_flipped            = o_flip_ff;
   assign rsp_site_spin          = o_spin_ff;
   assign rsp_spin_sum           = o_sum_ff;
   assign rsp_abs_spin_sum_total = o_abs_ff;

endmodule

// ----- hdl/ising_metropolis_spin_update.sv -----
// ----------------------------------------------------------------------------
// ising_metropolis_spin_update
// 2D Ising lattice with periodic wrap, Metropolis single-spin-flip update.
// ----------------------------------------------------------------------------
// Usage notes
//  - Request word: taken at a rising edge with start high and busy low.
//    req_mode 0 runs one Metropolis step at (req_row, req_col), both taken
//    modulo SIDE; req_mode 1 clears the lattice to all down.
//  - Result word: one per request, shown for exactly one cycle with
//    rsp_strobe high. The receiver cannot stall; it must take the word.
//  - Step: the lattice is kept as SIDE rows of SIDE bits in a one-read,
//    one-write memory; the up, down and own rows are read in turn, then the
//    flip decision with the row write-back, then the abs-total add. A new
//    word can be taken in the strobe cycle.
//  - Clear: one row zeroed per cycle; a new word can be taken in the
//    strobe cycle.
//  - Reset: thresholds go to 2^32 (always accept), sums to -SIDE^2 and 0,
//    and a clearing sweep of all SIDE rows runs; busy stays high during it.
//  - Thresholds: APB registers at 0x00/0x08/0x10/0x18, 33 bits each;
//    write them only while the block is idle.
// ----------------------------------------------------------------------------
module ising_metropolis_spin_update #(
   parameter int SIDE = 128
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request
   input  logic                                   start,
   output logic                                   busy,
   input  logic                                   req_mode,
   input  logic [ising_pkg::ROW_W-1:0]            req_row,
   input  logic [ising_pkg::ROW_W-1:0]            req_col,
   input  logic [ising_pkg::RND_W-1:0]            req_random_fraction,
   // result
   output logic                                   rsp_strobe,
   output logic                                   rsp_flipped,
   output logic                                   rsp_site_spin,
   output logic signed [ising_pkg::OUT_SUM_W-1:0] rsp_spin_sum,
   output logic [ising_pkg::ABS_W-1:0]            rsp_abs_spin_sum_total,
   // configuration
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [ising_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [ising_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [ising_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                   pready
);
   import ising_pkg::*;

   thr_set_type   thr;
   dp_cmd_type    cmd;
   dp_status_type status;

   // threshold registers
   ising_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .thr     (thr)
   );

   // sequencer
   ising_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   // lattice, decision and sums
   ising_dp #(
      .SIDE (SIDE)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .req_row                (req_row),
      .req_col                (req_col),
      .req_random_fraction    (req_random_fraction),
      .thr                    (thr),
      .rsp_strobe             (rsp_strobe),
      .rsp_flipped            (rsp_flipped),
      .rsp_site_spin          (rsp_site_spin),
      .rsp_spin_sum           (rsp_spin_sum),
      .rsp_abs_spin_sum_total (rsp_abs_spin_sum_total)
   );

endmodule

// ----- hdl/ising_checker.sv -----
// ----------------------------------------------------------------------------
// ising_checker
// Port-level temporal checks for the spin update block, bound to the top.
// ----------------------------------------------------------------------------
module ising_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe
);

   // accepted word keeps the block busy on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy low after accepting a word");

   // result comes out as the block returns to idle
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   // result follows work in progress
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe without preceding work");

   // one result per word, never two in a row
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("back-to-back result strobes");

endmodule

bind ising_metropolis_spin_update ising_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe)
);
